/* src/gast_pkg.sv */
package gast_pkg;

  // Field widths of the channels
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned TOL_W = 16;

  // Default coordinate width (low bits of each field that carry the value)
  localparam int unsigned COORD_WIDTH_DEF = 32;

  // Command queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // Class of a point against the tolerance band
  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_ABOVE,
    CLS_BELOW
  } cls_e;

  // Kind of vertex the back end emits
  typedef enum logic [1:0] {
    VK_PREV_AXIS,  // (previous x, 0)
    VK_CROSS,      // (crossing x, 0)
    VK_POINT,      // (x, y)
    VK_AXIS        // (x, 0)
  } vk_e;

  // Vertex list of one point; last_idx is the index of its final vertex
  typedef struct packed {
    vk_e        c0;
    vk_e        c1;
    vk_e        c2;
    vk_e        c3;
    logic [1:0] last_idx;
  } cmd_t;

  localparam int unsigned CMD_W = $bits(cmd_t);

  typedef enum logic {
    BK_RUN,
    BK_CALC
  } bk_state_e;

  typedef enum logic [2:0] {
    XU_IDLE,
    XU_MUL,
    XU_PREP,
    XU_DIV,
    XU_FIN
  } xu_state_e;

endpackage

/* src/gast_if.sv */
interface gast_point_if import gast_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] point_x;
  logic signed [FIELD_W-1:0] point_y;
  logic                      first_point;

  modport source (output valid, point_x, point_y, first_point, input ready);
  modport sink (input valid, point_x, point_y, first_point, output ready);
endinterface

interface gast_vertex_if import gast_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] vertex_x;
  logic signed [FIELD_W-1:0] vertex_y;
  logic                      last_vertex;

  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface gast_cfg_if import gast_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [TOL_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* src/gast_front.sv */
module gast_front import gast_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gast_point_if.sink                    point_i,
  gast_cfg_if.sink                      cfg_i,
  input  logic                          full_i,
  output logic                          push_o,
  output cmd_t                          cmd_o,
  output logic signed [COORD_WIDTH-1:0] x_o,
  output logic signed [COORD_WIDTH-1:0] y_o,
  output logic signed [COORD_WIDTH-1:0] px_o,
  output logic signed [COORD_WIDTH-1:0] py_o
);

  logic [TOL_W-1:0]              tol_q;
  logic signed [COORD_WIDTH-1:0] prev_x_q, prev_y_q;
  cls_e                          prev_cls_q, prev_cls_d;
  logic                          zero_run_q, zero_run_d;

  logic signed [COORD_WIDTH-1:0] x, y;
  logic signed [COORD_WIDTH:0]   yw, tw;
  cls_e                          cls, pc;
  logic                          zr, accept, has_out;
  vk_e                           p0, p1;

  assign cfg_i.ready   = 1'b1;
  assign point_i.ready = !full_i;
  assign accept        = point_i.valid && !full_i;

  // Coordinates are the low bits of the fields, taken as signed
  assign x  = COORD_WIDTH'(point_i.point_x);
  assign y  = COORD_WIDTH'(point_i.point_y);
  assign yw = (COORD_WIDTH+1)'(y);
  assign tw = signed'((COORD_WIDTH+1)'(tol_q));

  // Classify against the tolerance band
  always_comb begin
    if (yw > tw) begin
      cls = CLS_ABOVE;
    end else if (yw < -tw) begin
      cls = CLS_BELOW;
    end else begin
      cls = CLS_ZERO;
    end
  end

  // A new graph restarts from the point's own class
  assign pc = point_i.first_point ? cls : prev_cls_q;
  assign zr = point_i.first_point ? 1'b0 : zero_run_q;

  // Build the vertex list of the point
  always_comb begin
    p0         = (cls == CLS_ABOVE) ? VK_POINT : VK_AXIS;
    p1         = (cls == CLS_ABOVE) ? VK_AXIS : VK_POINT;
    cmd_o      = '{c0: p0, c1: p1, c2: VK_AXIS, c3: VK_AXIS, last_idx: 2'd1};
    has_out    = 1'b1;
    zero_run_d = zr;
    if (cls != CLS_ZERO) begin
      zero_run_d = 1'b0;
      if (zr) begin
        cmd_o = '{c0: VK_PREV_AXIS, c1: VK_PREV_AXIS, c2: p0, c3: p1, last_idx: 2'd3};
      end else if (cls != pc) begin
        cmd_o = '{c0: VK_CROSS, c1: p0, c2: p1, c3: VK_AXIS, last_idx: 2'd2};
      end
    end else if (pc != CLS_ZERO) begin
      cmd_o.c0 = VK_AXIS;
      cmd_o.c1 = VK_AXIS;
    end else begin
      has_out    = 1'b0;
      zero_run_d = 1'b1;
    end
  end

  assign prev_cls_d = cls;
  assign push_o     = accept && has_out;
  assign x_o        = x;
  assign y_o        = y;
  assign px_o       = prev_x_q;
  assign py_o       = prev_y_q;

  // Tolerance register and point history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q      <= '0;
      prev_x_q   <= '0;
      prev_y_q   <= '0;
      prev_cls_q <= CLS_ZERO;
      zero_run_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        tol_q <= cfg_i.data;
      end
      if (accept) begin
        prev_x_q   <= x;
        prev_y_q   <= y;
        prev_cls_q <= prev_cls_d;
        zero_run_q <= zero_run_d;
      end
    end
  end

endmodule

/* src/gast_fifo.sv */
module gast_fifo import gast_pkg::*; #(
  parameter int unsigned DW = CMD_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          full_o,
  output logic          empty_o
);

  logic [DW-1:0]         mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* src/gast_xunit.sv */
module gast_xunit import gast_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [COORD_WIDTH-1:0] x1_i,
  input  logic signed [COORD_WIDTH-1:0] y1_i,
  input  logic signed [COORD_WIDTH-1:0] x2_i,
  input  logic signed [COORD_WIDTH-1:0] y2_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] xc_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned NW = 2*W + 2;
  localparam int unsigned CW = $clog2(NW+1);

  xu_state_e state_q, state_d;
  logic [CW-1:0]        cnt_q;
  logic                 second_q;
  logic signed [NW-1:0] acc_q, mcand_q, term, acc_nx;
  logic [W-1:0]         mplier_q;
  logic signed [W-1:0]  x1_q, y2_q, x2_q;
  logic signed [W:0]    den_q;
  logic [W:0]           rem_q, dmag_q, rs;
  logic                 neg_q, ge, mul_last, div_last, sub;
  logic                 pos_ovf, neg_ovf;
  logic [W-1:0]         qsat;

  // Serial multiply step: acc +/- multiplicand for each multiplier bit
  assign mul_last = (cnt_q == CW'(W-1));
  assign sub      = mul_last ^ second_q;
  assign term     = mplier_q[0] ? mcand_q : '0;
  assign acc_nx   = sub ? acc_q - term : acc_q + term;

  // Restoring divide step, quotient shifts into acc
  assign div_last = (cnt_q == CW'(NW-1));
  assign rs       = {rem_q[W-1:0], acc_q[NW-1]};
  assign ge       = (rs >= dmag_q);

  // Saturate quotient magnitude to the signed coordinate range
  always_comb begin
    pos_ovf = |acc_q[NW-1:W-1];
    neg_ovf = (|acc_q[NW-1:W]) || (acc_q[W-1] && (|acc_q[W-2:0]));
    if (neg_q) begin
      qsat = neg_ovf ? {1'b1, {(W-1){1'b0}}} : acc_q[W-1:0];
    end else begin
      qsat = pos_ovf ? {1'b0, {(W-1){1'b1}}} : acc_q[W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      XU_IDLE: if (start_i) state_d = XU_MUL;
      XU_MUL:  if (mul_last && second_q) state_d = XU_PREP;
      XU_PREP: state_d = XU_DIV;
      XU_DIV:  if (div_last) state_d = XU_FIN;
      XU_FIN:  state_d = XU_IDLE;
      default: state_d = XU_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done_o = (state_q == XU_FIN);
    if (den_q == '0) begin
      xc_o = x2_q;
    end else begin
      xc_o = neg_q ? -signed'(qsat) : signed'(qsat);
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= XU_IDLE;
      cnt_q    <= '0;
      second_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        XU_IDLE: begin
          cnt_q    <= '0;
          second_q <= 1'b0;
        end
        XU_MUL: begin
          if (mul_last) begin
            cnt_q    <= '0;
            second_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        XU_PREP: cnt_q <= '0;
        XU_DIV:  cnt_q <= cnt_q + 1'b1;
        default: cnt_q <= '0;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      XU_IDLE: begin
        if (start_i) begin
          acc_q    <= '0;
          mcand_q  <= NW'(y1_i);
          mplier_q <= x2_i;
          x1_q     <= x1_i;
          y2_q     <= y2_i;
          x2_q     <= x2_i;
          den_q    <= (W+1)'(y1_i) - (W+1)'(y2_i);
        end
      end
      XU_MUL: begin
        acc_q <= acc_nx;
        if (mul_last && !second_q) begin
          mcand_q  <= NW'(y2_q);
          mplier_q <= x1_q;
        end else begin
          mcand_q  <= mcand_q <<< 1;
          mplier_q <= mplier_q >> 1;
        end
      end
      XU_PREP: begin
        acc_q  <= acc_q[NW-1] ? -acc_q : acc_q;
        rem_q  <= '0;
        dmag_q <= den_q[W] ? unsigned'(-den_q) : unsigned'(den_q);
        neg_q  <= acc_q[NW-1] ^ den_q[W];
      end
      XU_DIV: begin
        acc_q <= {acc_q[NW-2:0], ge};
        rem_q <= ge ? rs - dmag_q : rs;
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/gast_back.sv */
module gast_back import gast_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  cmd_t                          cmd_i,
  input  logic signed [COORD_WIDTH-1:0] x_i,
  input  logic signed [COORD_WIDTH-1:0] y_i,
  input  logic signed [COORD_WIDTH-1:0] px_i,
  input  logic signed [COORD_WIDTH-1:0] py_i,
  output logic                          pop_o,
  gast_vertex_if.source                 vertex_o
);

  bk_state_e state_q, state_d;
  logic [1:0]                    idx_q;
  logic                          xdone_q, ovalid_q;
  logic signed [COORD_WIDTH-1:0] xc_q, xc;
  logic                          xu_start, xu_done, emit, slot_free, need_x;
  vk_e                           code;
  logic signed [FIELD_W-1:0]     vx, vy;

  gast_xunit #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_xunit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (xu_start),
    .x1_i    (px_i),
    .y1_i    (py_i),
    .x2_i    (x_i),
    .y2_i    (y_i),
    .done_o  (xu_done),
    .xc_o    (xc)
  );

  // Current vertex of the head command
  always_comb begin
    unique case (idx_q)
      2'd0:    code = cmd_i.c0;
      2'd1:    code = cmd_i.c1;
      2'd2:    code = cmd_i.c2;
      default: code = cmd_i.c3;
    endcase
  end

  assign slot_free = !ovalid_q || vertex_o.ready;
  assign need_x    = (code == VK_CROSS) && !xdone_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_RUN:  if (!empty_i && need_x) state_d = BK_CALC;
      BK_CALC: if (xu_done) state_d = BK_RUN;
      default: state_d = BK_RUN;
    endcase
  end

  // Outputs
  always_comb begin
    xu_start = (state_q == BK_RUN) && !empty_i && need_x;
    emit     = (state_q == BK_RUN) && !empty_i && !need_x && slot_free;
    pop_o    = emit && (idx_q == cmd_i.last_idx);
  end

  // Vertex value
  always_comb begin
    vy = '0;
    unique case (code)
      VK_PREV_AXIS: vx = FIELD_W'(px_i);
      VK_CROSS:     vx = FIELD_W'(xc_q);
      VK_POINT: begin
        vx = FIELD_W'(x_i);
        vy = FIELD_W'(y_i);
      end
      default:      vx = FIELD_W'(x_i);
    endcase
  end

  assign vertex_o.valid = ovalid_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_RUN;
      idx_q    <= '0;
      xdone_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        ovalid_q <= 1'b1;
        idx_q    <= pop_o ? 2'd0 : idx_q + 2'd1;
      end else if (vertex_o.ready) begin
        ovalid_q <= 1'b0;
      end
      if (xu_done) begin
        xdone_q <= 1'b1;
      end else if (pop_o) begin
        xdone_q <= 1'b0;
      end
    end
  end

  // Output register and crossing result
  always_ff @(posedge clk_i) begin
    if (xu_done) begin
      xc_q <= xc;
    end
    if (emit) begin
      vertex_o.vertex_x    <= vx;
      vertex_o.vertex_y    <= vy;
      vertex_o.last_vertex <= pop_o;
    end
  end

endmodule

/* src/graph_area_strip_tessellator.sv */
// Channel   Dir  Payload                              Transfer
// point_i   in   point_x, point_y, first_point        valid && ready
// vertex_o  out  vertex_x, vertex_y, last_vertex      valid && ready
// cfg_i     in   data (zero_tolerance)                valid && ready
//
// A point is taken while the command queue is not full; its 0 to 4 vertices
// leave one per cycle while vertex_o is ready. A point that needs an axis
// crossing first waits for the bit-serial multiplier and restoring divider.
// A four-entry command queue lets points enter while vertices are stalled.
// Reset is asynchronous, active low; tolerance resets to 0. cfg_i is always ready.
module graph_area_strip_tessellator import gast_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gast_point_if.sink    point_i,
  gast_cfg_if.sink      cfg_i,
  gast_vertex_if.source vertex_o
);

  localparam int unsigned DW = CMD_W + 4*COORD_WIDTH;

  logic                          push, pop, full, empty;
  cmd_t                          cmd_in, cmd_hd;
  logic signed [COORD_WIDTH-1:0] x_in, y_in, px_in, py_in;
  logic signed [COORD_WIDTH-1:0] x_hd, y_hd, px_hd, py_hd;
  logic [DW-1:0]                 wdata, rdata;

  gast_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .point_i (point_i),
    .cfg_i   (cfg_i),
    .full_i  (full),
    .push_o  (push),
    .cmd_o   (cmd_in),
    .x_o     (x_in),
    .y_o     (y_in),
    .px_o    (px_in),
    .py_o    (py_in)
  );

  assign wdata = {cmd_in, x_in, y_in, px_in, py_in};

  gast_fifo #(
    .DW(DW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (wdata),
    .pop_i   (pop),
    .data_o  (rdata),
    .full_o  (full),
    .empty_o (empty)
  );

  assign {cmd_hd, x_hd, y_hd, px_hd, py_hd} = rdata;

  gast_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .cmd_i    (cmd_hd),
    .x_i      (x_hd),
    .y_i      (y_hd),
    .px_i     (px_hd),
    .py_i     (py_hd),
    .pop_o    (pop),
    .vertex_o (vertex_o)
  );

endmodule

/* src/gast_checker.sv */
module gast_checker import gast_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               out_last_i,
  input logic [FIELD_W-1:0] out_x_i,
  input logic [FIELD_W-1:0] out_y_i
);

  logic       seen_q;
  logic [7:0] open_q;
  logic       in_xfer, last_xfer;

  assign in_xfer   = in_valid_i && in_ready_i;
  assign last_xfer = out_valid_i && out_ready_i && out_last_i;

  // Points taken versus final vertices given; sticks once saturated
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      open_q <= '0;
    end else begin
      if (in_xfer) begin
        seen_q <= 1'b1;
      end
      if (open_q != 8'hFF) begin
        open_q <= open_q + {7'd0, in_xfer} - {7'd0, last_xfer};
      end
    end
  end

  // A stalled vertex holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_i) &&
      $stable(out_y_i) && $stable(out_last_i))
    else $error("vertex changed while stalled");

  // No vertex before any point
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> seen_q)
    else $error("vertex without a point");

  // Each final vertex belongs to an earlier point
  a_last_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_xfer |-> (open_q != 8'd0))
    else $error("more final vertices than points");

endmodule

bind graph_area_strip_tessellator gast_checker u_gast_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (point_i.valid),
  .in_ready_i  (point_i.ready),
  .out_valid_i (vertex_o.valid),
  .out_ready_i (vertex_o.ready),
  .out_last_i  (vertex_o.last_vertex),
  .out_x_i     (vertex_o.vertex_x),
  .out_y_i     (vertex_o.vertex_y)
);

/* test/graph_area_strip_tessellator_tb.sv */
module graph_area_strip_tessellator_tb;
  import gast_pkg::*;

  localparam int unsigned CW = COORD_WIDTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               first;
  } point_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
  } vertex_t;

  logic clk_i;
  logic rst_ni;

  gast_point_if  point_if ();
  gast_vertex_if vertex_if ();
  gast_cfg_if    cfg_if ();

  graph_area_strip_tessellator i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .point_i (point_if.sink),
    .cfg_i   (cfg_if.sink),
    .vertex_o(vertex_if.source)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state
  logic signed [31:0] pr_x, pr_y;
  cls_e               pr_cls;
  logic               pr_zrun;
  logic [15:0]        tol_q;

  point_t  pending_points[$];
  vertex_t expected_vertices[$];

  int unsigned cycles;
  int unsigned mismatches;
  int unsigned vertex_count;
  int unsigned point_count;
  int unsigned cross_count;
  bit          quiet;

  // Exact crossing: (y1*x2 - y2*x1) / (y1 - y2), truncated, saturated
  function automatic logic signed [31:0] cross_x(logic signed [31:0] x1,
      logic signed [31:0] y1, logic signed [31:0] x2, logic signed [31:0] y2);
    logic signed [127:0] num, den, q;
    logic signed [127:0] lim_hi, lim_lo;
    num = 128'(y1) * 128'(x2) - 128'(y2) * 128'(x1);
    den = 128'(y1) - 128'(y2);
    if (den == 0) return x2;
    q = num / den;
    lim_hi = (128'sd1 <<< (CW - 1)) - 1;
    lim_lo = -(128'sd1 <<< (CW - 1));
    if (q > lim_hi) q = lim_hi;
    if (q < lim_lo) q = lim_lo;
    return q[31:0];
  endfunction

  function automatic void push_vertex(logic signed [31:0] x, logic signed [31:0] y);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.last = 1'b0;
    expected_vertices = {expected_vertices, v};
  endfunction

  // Strip vertices caused by one point
  function automatic void predict_vertices(point_t p);
    logic signed [32:0] tol;
    cls_e cls;
    int   n0;
    n0 = expected_vertices.size();
    tol = {17'd0, tol_q};
    if (33'(p.y) > tol) cls = CLS_ABOVE;
    else if (33'(p.y) < -tol) cls = CLS_BELOW;
    else cls = CLS_ZERO;
    if (p.first) begin
      pr_cls = cls;
      pr_zrun = 1'b0;
    end
    if (cls != CLS_ZERO) begin
      if (pr_zrun) begin
        push_vertex(pr_x, 0);
        push_vertex(pr_x, 0);
        pr_zrun = 1'b0;
      end else if (cls != pr_cls) begin
        push_vertex(cross_x(pr_x, pr_y, p.x, p.y), 0);
        cross_count++;
      end
      if (cls == CLS_ABOVE) begin
        push_vertex(p.x, p.y);
        push_vertex(p.x, 0);
      end else begin
        push_vertex(p.x, 0);
        push_vertex(p.x, p.y);
      end
    end else if (pr_cls != CLS_ZERO) begin
      push_vertex(p.x, 0);
      push_vertex(p.x, 0);
    end else begin
      pr_zrun = 1'b1;
    end
    pr_cls = cls;
    pr_x = p.x;
    pr_y = p.y;
    if (expected_vertices.size() > n0)
      expected_vertices[expected_vertices.size() - 1].last = 1'b1;
  endfunction

  // Point driver with idle bursts
  int unsigned src_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_if.valid <= 1'b0;
      point_if.point_x <= '0;
      point_if.point_y <= '0;
      point_if.first_point <= 1'b0;
      src_gap = 0;
    end else begin
      if (point_if.valid && point_if.ready) begin
        predict_vertices(pending_points.pop_front());
        point_count++;
        if (!quiet && $urandom_range(0, 4) == 0) src_gap = $urandom_range(1, 4);
      end
      if (src_gap > 0 && !(point_if.valid && !point_if.ready)) begin
        src_gap--;
        point_if.valid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        point_if.valid <= 1'b1;
        point_if.point_x <= pending_points[0].x;
        point_if.point_y <= pending_points[0].y;
        point_if.first_point <= pending_points[0].first;
      end else begin
        point_if.valid <= 1'b0;
      end
    end
  end

  // Vertex monitor with random stalls
  int unsigned snk_stall;
  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t e;
    if (!rst_ni) begin
      vertex_if.ready <= 1'b0;
      snk_stall = 0;
    end else begin
      cycles++;
      if (vertex_if.valid && vertex_if.ready) begin
        vertex_count++;
        if (expected_vertices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected vertex x=%0d y=%0d last=%0b",
                     vertex_if.vertex_x, vertex_if.vertex_y, vertex_if.last_vertex);
        end else begin
          e = expected_vertices.pop_front();
          if (e.x !== vertex_if.vertex_x || e.y !== vertex_if.vertex_y ||
              e.last !== vertex_if.last_vertex) begin
            mismatches++;
            if (mismatches <= 10)
              $display("vertex mismatch: exp x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                       e.x, e.y, e.last, vertex_if.vertex_x, vertex_if.vertex_y,
                       vertex_if.last_vertex);
          end
        end
      end
      if (snk_stall > 0) begin
        snk_stall--;
        vertex_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        snk_stall = $urandom_range(0, 3);
        vertex_if.ready <= 1'b0;
      end else begin
        vertex_if.ready <= 1'b1;
      end
    end
  end

  // Run timeout
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_points.size() > 0 || expected_vertices.size() > 0 || point_if.valid)
      @(posedge clk_i);
    repeat (4 * CW + 20) @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [15:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    tol_q = value;
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_y(logic [15:0] tol);
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 2 * tol) - tol;          // inside the band
      1: return tol + 1;
      2: return -tol - 1;
      3: return $urandom_range(0, 1) ? tol : -tol;
      4: return $urandom;
      default: return $signed($urandom_range(0, 600000)) - 300000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_x();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $signed($urandom_range(0, 2000000)) - 1000000;
  endfunction

  task automatic add_point(logic signed [31:0] x, logic signed [31:0] y, logic f);
    point_t p;
    p.x = x;
    p.y = y;
    p.first = f;
    pending_points = {pending_points, p};
  endtask

  // Random graphs for the current tolerance
  task automatic random_graphs(int unsigned count, logic [15:0] tol);
    logic signed [31:0] x;
    for (int i = 0; i < count; i++) begin
      x = rand_x();
      add_point(x, rand_y(tol), (i == 0) || ($urandom_range(0, 15) == 0));
    end
  endtask

  // Stimulus
  initial begin
    logic [15:0] tols[5];
    tols = '{16'd0, 16'hFFFF, 16'd1, 16'd100, 16'd32768};
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    point_if.valid = 1'b0;
    vertex_if.ready = 1'b0;
    pr_x = 0; pr_y = 0; pr_cls = CLS_ZERO; pr_zrun = 1'b0; tol_q = '0;
    cycles = 0; mismatches = 0; vertex_count = 0; point_count = 0; cross_count = 0;
    quiet = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: no first point, crossings, zero runs, extremes
    add_point(32'sd5, 32'sd10, 1'b0);
    add_point(32'sd9, -32'sd10, 1'b0);
    add_point(32'sd12, 32'sd0, 1'b0);
    add_point(32'sd13, 32'sd0, 1'b0);
    add_point(32'sd14, 32'sd0, 1'b0);
    add_point(32'sd15, -32'sd7, 1'b0);
    add_point(32'sd16, 32'sd0, 1'b1);
    add_point(32'sd17, 32'sd4, 1'b0);
    add_point(32'sd18, 32'sd0, 1'b0);
    add_point(32'sd19, -32'sd3, 1'b0);
    add_point(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1);
    add_point(32'h80000000, 32'h80000000, 1'b0);
    add_point(32'h80000000, 32'sd1, 1'b0);
    add_point(32'h7FFFFFFF, 32'sh80000000, 1'b0);
    add_point(32'h7FFFFFFF, -32'sd1, 1'b0);
    add_point(32'h80000000, 32'h7FFFFFFF, 1'b0);
    add_point(-32'sd1, -32'sd1, 1'b1);
    add_point(32'h55555555, 32'hAAAAAAAA, 1'b0);
    add_point(32'hAAAAAAAA, 32'h55555555, 1'b0);
    wait_drained();

    // Equal y at a crossing after a tolerance change
    write_tolerance(16'd0);
    add_point(32'sd100, 32'sd50, 1'b1);
    wait_drained();
    write_tolerance(16'd60);
    add_point(32'sd200, 32'sd50, 1'b0);
    wait_drained();
    write_tolerance(16'd0);
    add_point(32'sd300, 32'sd50, 1'b0);
    add_point(32'sd400, -32'sd61, 1'b0);
    add_point(32'sd500, 32'sd61, 1'b0);
    wait_drained();

    // Random phases over several tolerances
    foreach (tols[k]) begin
      write_tolerance(tols[k]);
      if (k == 4) quiet = 1'b1;
      random_graphs(70, tols[k]);
      wait_drained();
    end

    $display("%0d points, %0d vertices, %0d axis crossings over five tolerance settings",
             point_count, vertex_count, cross_count);
    if (mismatches == 0 && expected_vertices.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d vertices outstanding", mismatches,
               expected_vertices.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/gast_pkg.sv
src/gast_if.sv
src/gast_front.sv
src/gast_fifo.sv
src/gast_xunit.sv
src/gast_back.sv
src/graph_area_strip_tessellator.sv
src/gast_checker.sv
test/graph_area_strip_tessellator_tb.sv
